### src/key_click_long_press_detector_defines.svh
// assertion macros used by the key click detector state machine
`ifndef KEY_CLICK_LONG_PRESS_DETECTOR_DEFINES_SVH
`define KEY_CLICK_LONG_PRESS_DETECTOR_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define KCLPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on i_clk outside reset
`define KCLPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/kclpd_pkg.sv
// types and constants of the key click / long press detector
package kclpd_pkg;

    localparam int COUNT_BITS = 10;
    localparam int THR_BITS   = 10;
    localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WAIT = CFG_IDX_W'(1);

    localparam logic [THR_BITS-1:0] LONG_PRESS_RESET  = THR_BITS'(50);
    localparam logic [THR_BITS-1:0] DOUBLE_WAIT_RESET = THR_BITS'(15);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_DEB    = 3'd1,
        PH_PRESS  = 3'd2,
        PH_LONG   = 3'd3,
        PH_WAIT   = 3'd4,
        PH_SECOND = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    typedef struct packed {
        logic [THR_BITS-1:0] long_press_ticks;
        logic [THR_BITS-1:0] double_wait_ticks;
    } t_cfg;

    typedef struct packed {
        t_event event_res;
        t_phase phase;
    } t_result;

endpackage

### src/kclpd_cfg.sv
// threshold configuration registers
module kclpd_cfg import kclpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks  <= LONG_PRESS_RESET;
            r_cfg.double_wait_ticks <= DOUBLE_WAIT_RESET;
        end else if (i_we) begin
            case (i_index)
                REG_LONG_PRESS:  r_cfg.long_press_ticks  <= THR_BITS'(i_data);
                REG_DOUBLE_WAIT: r_cfg.double_wait_ticks <= THR_BITS'(i_data);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/kclpd_fsm.sv
// key state machine with the shared tick counter
module kclpd_fsm import kclpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_key_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

`include "key_click_long_press_detector_defines.svh"

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;
    t_event                ev;
    logic                  pressed;
    logic [CMP_BITS-1:0]   cnt_ext, long_ext, wait_ext;
    logic                  cnt_sat;

    assign pressed  = !i_key_level;
    assign cnt_ext  = CMP_BITS'(r_count);
    assign long_ext = CMP_BITS'(i_cfg.long_press_ticks);
    assign wait_ext = CMP_BITS'(i_cfg.double_wait_ticks);
    assign cnt_sat  = (r_count == COUNT_MAX);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        ev      = EV_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (pressed) n_phase = PH_DEB;
            end
            PH_DEB: begin
                n_phase = pressed ? PH_PRESS : PH_IDLE;
            end
            PH_PRESS, PH_SECOND: begin
                if (pressed) begin
                    if (cnt_ext >= long_ext) begin
                        n_count = '0;
                        n_phase = PH_LONG;
                    end else if (!cnt_sat) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_count = '0;
                    if (r_phase == PH_PRESS) begin
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_IDLE;
                        ev      = EV_DOUBLE;
                    end
                end
            end
            PH_LONG: begin
                n_count = '0;
                if (!pressed) begin
                    n_phase = PH_IDLE;
                    ev      = EV_LONG;
                end
            end
            PH_WAIT: begin
                if (!pressed) begin
                    if (cnt_ext >= wait_ext) begin
                        n_count = '0;
                        n_phase = PH_IDLE;
                        ev      = EV_SINGLE;
                    end else if (!cnt_sat) begin
                        n_count = r_count + 1'b1;
                    end
                end else begin
                    n_count = '0;
                    n_phase = PH_SECOND;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    assign o_result.event_res = ev;
    assign o_result.phase     = n_phase;

    // counter only runs in the press, second press and wait states
    `KCLPD_ASSERT_NOW(a_count_clear, (r_phase == PH_IDLE || r_phase == PH_DEB || r_phase == PH_LONG), (r_count == '0))
    // no tick, no state change
    `KCLPD_ASSERT_NEXT(a_hold_no_step, !i_step, ($stable(r_phase) && $stable(r_count)))
    // every event lands the machine back in idle
    `KCLPD_ASSERT_NOW(a_event_idle, (o_result.event_res != EV_NONE), (o_result.phase == PH_IDLE))

endmodule

### src/key_click_long_press_detector.sv
// key click, double click and long press detector top level
// Takes one active-low key sample per input transaction and returns one result
// transaction per sample: the event (none, single click, double click, long
// press) and the machine state after that sample. A new sample is taken every
// clock cycle unless the input stalls; a sample is held in the input register
// and its result is then captured in the result register. The state update is
// a single compare-and-increment on the tick counter, done as the sample moves
// from the input register into the result register. While a finished result
// waits to be taken the input register can still take one more sample; with
// both registers full the input stalls until the result is taken. Thresholds
// are written through the configuration port, which is always ready; write
// them only while no transaction is in flight. Long press is reported on
// release, and the counter saturates at its threshold and at its own all-ones
// value.
module key_click_long_press_detector import kclpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_key_level,
    // result output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_event_res,
    output logic [2:0]            o_phase,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // input register stage
    logic    r_in_valid;
    logic    r_key;
    // result register stage
    logic    r_out_valid;
    t_result r_out;

    logic    out_free;   // result register can take a new result this cycle
    logic    advance;    // sample moves from input register into result register
    logic    in_take;    // input transaction accepted
    t_cfg    cfg;
    t_result result;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign in_take  = i_valid && o_ready;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    kclpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // machine state advances exactly once per sample, as it leaves the input register
    kclpd_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_key_level (r_key),
        .i_cfg       (cfg),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_key <= i_key_level;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_event_res = r_out.event_res;
    assign o_phase     = r_out.phase;

endmodule

### tb/key_click_long_press_detector_test.sv
// self-checking testbench for the key click, double click and long press detector
module key_click_long_press_detector_test;
    import kclpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // idling profiles: sender idles 31% / receiver 59%, then swapped, then none
    localparam logic [1:0] IDLE_TX_LIGHT = 2'd0;
    localparam logic [1:0] IDLE_TX_HEAVY = 2'd1;
    localparam logic [1:0] IDLE_NONE     = 2'd2;

    // cycles the receiver holds off when a long stall is requested
    localparam int LONG_STALL_CYCLES = 60;
    // settle time after the last result
    localparam int SETTLE_CYCLES     = 6;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_key_level;
    logic                  o_valid;
    logic                  i_ready;
    logic [1:0]            o_event_res;
    logic [2:0]            o_phase;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    key_click_long_press_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_key_level (i_key_level),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_event_res (o_event_res),
        .o_phase     (o_phase),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predicts the key state machine and holds the events still owed by the block
    class key_event_scoreboard;
        logic [THR_BITS-1:0]   long_thr;
        logic [THR_BITS-1:0]   wait_thr;
        t_phase                key_state;
        logic [COUNT_BITS-1:0] ticks;
        t_result               owed_q[$];
        int                    errors;

        function new();
            long_thr  = LONG_PRESS_RESET;
            wait_thr  = DOUBLE_WAIT_RESET;
            key_state = PH_IDLE;
            ticks     = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_LONG_PRESS) begin
                long_thr = data;
            end else if (index == REG_DOUBLE_WAIT) begin
                wait_thr = data;
            end
        endfunction

        // counter saturates at the threshold and at its own all-ones value
        function void bump(logic [THR_BITS-1:0] lim);
            if (ticks < lim && ticks < COUNT_MAX) begin
                ticks = ticks + 1'b1;
            end
        endfunction

        function void note_sample(logic key_level);
            t_result r;
            logic    pressed;
            pressed     = ~key_level;
            r.event_res = EV_NONE;
            case (key_state)
                PH_IDLE: begin
                    if (pressed) begin
                        key_state = PH_DEB;
                    end
                end
                PH_DEB: begin
                    if (pressed) begin
                        key_state = PH_PRESS;
                    end else begin
                        key_state = PH_IDLE;
                    end
                end
                PH_PRESS, PH_SECOND: begin
                    if (pressed) begin
                        if (ticks >= long_thr) begin
                            ticks     = '0;
                            key_state = PH_LONG;
                        end else begin
                            bump(long_thr);
                        end
                    end else begin
                        ticks = '0;
                        if (key_state == PH_PRESS) begin
                            key_state = PH_WAIT;
                        end else begin
                            key_state   = PH_IDLE;
                            r.event_res = EV_DOUBLE;
                        end
                    end
                end
                PH_LONG: begin
                    // long press is reported on release only
                    if (!pressed) begin
                        key_state   = PH_IDLE;
                        r.event_res = EV_LONG;
                    end
                    ticks = '0;
                end
                PH_WAIT: begin
                    if (!pressed) begin
                        if (ticks >= wait_thr) begin
                            ticks       = '0;
                            key_state   = PH_IDLE;
                            r.event_res = EV_SINGLE;
                        end else begin
                            bump(wait_thr);
                        end
                    end else begin
                        ticks     = '0;
                        key_state = PH_SECOND;
                    end
                end
                default: ;
            endcase
            r.phase = key_state;
            owed_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [1:0] ev, logic [2:0] ph);
            t_result exp;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: event %0d phase %0d",
                                          ev, ph));
            end else begin
                exp = owed_q.pop_front();
                if (ev !== exp.event_res) begin
                    report_mismatch($sformatf("event got %0d want %s",
                                              ev, exp.event_res.name()));
                end
                if (ph !== exp.phase) begin
                    report_mismatch($sformatf("phase got %0d want %s",
                                              ph, exp.phase.name()));
                end
            end
        endtask

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    key_event_scoreboard sb;
    logic [1:0]          idle_mode;
    int                  stall_asks;
    int                  samples_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous ceiling on the whole run
    initial begin
        #5000000;
        $display("key_click_long_press_detector_test: errors");
        $finish;
    end

    function int tx_idle_pct();
        case (idle_mode)
            IDLE_TX_LIGHT: return 31;
            IDLE_TX_HEAVY: return 59;
            default:       return 0;
        endcase
    endfunction

    function int rx_idle_pct();
        case (idle_mode)
            IDLE_TX_LIGHT: return 59;
            IDLE_TX_HEAVY: return 31;
            default:       return 0;
        endcase
    endfunction

    // result side: random ready, plus a long hold-off whenever one is requested
    initial begin : result_sink
        int hold_left;
        int stall_seen;
        hold_left  = 0;
        stall_seen = 0;
        i_ready    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_asks != stall_seen) begin
                stall_seen = stall_asks;
                hold_left  = LONG_STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_idle_pct());
            end
        end
    end

    // every result transaction is checked against the oldest owed event
    initial begin : result_monitor
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                sb.check_result(o_event_res, o_phase);
            end
        end
    end

    // one sample transaction; random gaps ahead of it, valid held until taken
    task send_sample(logic level);
        while ($urandom_range(99) < tx_idle_pct()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_key_level <= level;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(level);
        samples_sent++;
    endtask

    task press_for(int n);
        repeat (n) send_sample(1'b0);
    endtask

    task release_for(int n);
        repeat (n) send_sample(1'b1);
    endtask

    // '0' pressed, '1' released
    task send_pattern(string bits);
        for (int k = 0; k < bits.len(); k++) begin
            send_sample(bits[k] == "1");
        end
    endtask

    // stop offering and wait until every owed result has come back
    task drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both thresholds back to back, valid kept high across the two transactions
    task write_config(logic [CFG_DATA_W-1:0] long_ticks, logic [CFG_DATA_W-1:0] wait_ticks);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_LONG_PRESS;
        i_cfg_data  <= long_ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_LONG_PRESS, long_ticks);
        i_cfg_index <= REG_DOUBLE_WAIT;
        i_cfg_data  <= wait_ticks;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(REG_DOUBLE_WAIT, wait_ticks);
        i_cfg_valid <= 1'b0;
    endtask

    // random duration that stays cheap when the threshold is large
    function int span(int thr);
        return 1 + $urandom_range(0, (thr > 60) ? 8 : thr + 3);
    endfunction

    // one gesture: mostly well-formed clicks with random timing, some noise
    task play_gesture(int long_thr, int wait_thr);
        case ($urandom_range(9))
            0: begin
                repeat ($urandom_range(1, 8)) send_sample($urandom_range(1));
            end
            1: send_pattern("01");
            2, 3, 4: begin
                // single click, release long enough to cross the wait most times
                press_for(span(long_thr));
                if (wait_thr <= 60) begin
                    release_for(wait_thr + $urandom_range(0, 3));
                end else begin
                    release_for(span(wait_thr));
                end
            end
            5, 6, 7: begin
                // double click attempt, gap usually inside the wait window
                press_for(span(long_thr));
                release_for(span(wait_thr));
                press_for(span(long_thr));
                release_for(span(wait_thr));
            end
            default: begin
                // long press around the threshold boundary
                if (long_thr <= 60) begin
                    press_for(long_thr + $urandom_range(1, 6));
                end else begin
                    press_for(span(long_thr));
                end
                release_for($urandom_range(1, 3));
            end
        endcase
    endtask

    // one configuration setting with random gestures, one long receiver stall
    // and one sender pause until everything owed has come back
    task run_phase(logic [CFG_DATA_W-1:0] long_ticks, logic [CFG_DATA_W-1:0] wait_ticks,
                   int budget);
        int  first;
        bit  stalled;
        bit  paused;
        first   = samples_sent;
        stalled = 1'b0;
        paused  = 1'b0;
        drain();
        write_config(long_ticks, wait_ticks);
        while (samples_sent - first < budget) begin
            if (!stalled && samples_sent - first >= budget / 3) begin
                stall_asks <= stall_asks + 1;
                stalled = 1'b1;
            end else if (!paused && samples_sent - first >= (2 * budget) / 3) begin
                drain();
                paused = 1'b1;
            end
            play_gesture(long_ticks, wait_ticks);
        end
    endtask

    initial begin : stimulus
        sb           = new();
        samples_sent = 0;
        stall_asks   = 0;
        idle_mode    = IDLE_TX_LIGHT;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_key_level  = 1'b1;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_LONG_PRESS;
        i_cfg_data   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: idle tick and a one-tick glitch that debounce rejects
        send_pattern("101");
        drain();
        write_config(CFG_DATA_W'(2), CFG_DATA_W'(1));
        send_pattern("000111");   // single click
        send_pattern("00101");    // double click
        send_pattern("000001");   // long press reported on release
        drain();
        // zero thresholds are met on the first qualifying tick
        write_config('0, '0);
        send_pattern("0011");     // single click at once
        send_pattern("001001");   // second press turns into a long press

        run_phase(LONG_PRESS_RESET, DOUBLE_WAIT_RESET, 100);
        run_phase(CFG_DATA_W'(3), CFG_DATA_W'(2), 70);
        run_phase('0, '0, 50);

        idle_mode <= IDLE_TX_HEAVY;
        // largest thresholds: the press counter climbs all the way to all-ones,
        // the wait counter only part of the way
        drain();
        write_config('1, '1);
        press_for(1027);
        release_for(2);
        press_for(4);
        release_for(24);
        send_pattern("000110001");
        run_phase(CFG_DATA_W'(1), '0, 50);
        run_phase('0, '1, 40);

        idle_mode <= IDLE_NONE;
        run_phase(CFG_DATA_W'(7), CFG_DATA_W'(5), 70);
        run_phase('1, '0, 30);
        run_phase(CFG_DATA_W'($urandom_range(0, 20)), CFG_DATA_W'($urandom_range(0, 20)), 50);

        drain();
        if (sb.errors == 0) begin
            $display("key_click_long_press_detector_test: clean");
        end else begin
            $display("key_click_long_press_detector_test: errors");
        end
        $finish;
    end

endmodule
